// ===== hw/rtl/tsd_pkg.sv =====
// Package for the thermometer seven-segment display block.
// Holds the shared constants, the digit record type and the glyph lookup.
// Depends on nothing; used by the interfaces and every module of the block.
package tsd_pkg;

    localparam int CODE_W    = 8;
    localparam int SEG_W     = 7;
    localparam int SEL_W     = 4;
    localparam int CELSIUS_W = 9;   // 0..500
    localparam int VALUE_W   = 10;  // 0..932
    localparam int DIGIT_W   = 4;

    // Celsius = floor(code * 100 / 51), done as code * ceil(100 * 2^20 / 51) >> 20.
    localparam logic [21:0] CELSIUS_MUL = 22'd2056032;
    // Fahrenheit core = floor(c * 9 / 5), done as c * 9 * ceil(2^16 / 5) >> 16.
    localparam logic [16:0] FAHR_MUL    = 17'd117972;
    localparam logic [9:0]  FAHR_OFFSET = 10'd32;
    // Decimal split: v / 10 = v * 205 >> 11 and v / 100 = v * 41 >> 12, exact below 1000.
    localparam logic [7:0]  DIV10_MUL   = 8'd205;
    localparam logic [5:0]  DIV100_MUL  = 6'd41;

    localparam logic [6:0] SEG_LETTER_C = 7'h39;
    localparam logic [6:0] SEG_LETTER_F = 7'h71;

    localparam logic [1:0] FRAME_LETTER   = 2'd0;
    localparam logic [1:0] FRAME_UNITS    = 2'd1;
    localparam logic [1:0] FRAME_TENS     = 2'd2;
    localparam logic [1:0] FRAME_HUNDREDS = 2'd3;

    typedef struct packed {
        logic               fahrenheit;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } digits_t;

    function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7C;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== hw/rtl/tsd_channels.sv =====
// Handshake channels of the thermometer display: sample words in, frame words out.
// Depends on tsd_pkg for the field widths.
interface tsd_sample_if;
    logic                         valid;
    logic                         ready;
    logic [tsd_pkg::CODE_W-1:0]   adc_code;
    logic                         button_level;

    modport source (output valid, output adc_code, output button_level, input ready);
    modport sink   (input valid, input adc_code, input button_level, output ready);
endinterface

interface tsd_frame_if;
    logic                         valid;
    logic                         ready;
    logic [tsd_pkg::SEG_W-1:0]    segments;
    logic [tsd_pkg::SEL_W-1:0]    digit_select;
    logic                         last_frame;

    modport source (output valid, output segments, output digit_select, output last_frame,
                    input ready);
    modport sink   (input valid, input segments, input digit_select, input last_frame,
                    output ready);
endinterface

// ===== hw/rtl/tsd_framer.sv =====
// Frame sequencer: holds the decimal digits of one sample and plays them out as frames.
// Depends on tsd_pkg and the tsd_frame_if channel.
module tsd_framer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tsd_pkg::digits_t digits,
    output logic             load_ok,
    tsd_frame_if.source      frame
);

    logic             valid_reg;
    logic             valid_next;
    logic [1:0]       index_reg;
    logic [1:0]       index_next;
    tsd_pkg::digits_t digits_reg;
    logic [1:0]       final_index;
    logic             is_last;
    logic             done;

    assign final_index = digits_reg.fahrenheit ? tsd_pkg::FRAME_HUNDREDS : tsd_pkg::FRAME_TENS;
    assign is_last     = (index_reg == final_index);
    assign done        = valid_reg && frame.ready && is_last;
    assign load_ok     = !valid_reg || done;

    always_comb
    begin
        valid_next = valid_reg;
        index_next = index_reg;
        if (load)
        begin
            valid_next = 1'b1;
            index_next = tsd_pkg::FRAME_LETTER;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (valid_reg && frame.ready)
        begin
            index_next = index_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            index_reg <= tsd_pkg::FRAME_LETTER;
        end
        else
        begin
            valid_reg <= valid_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digits_reg <= digits;
        end
    end

    always_comb
    begin
        unique case (index_reg)
            tsd_pkg::FRAME_LETTER:
                frame.segments = digits_reg.fahrenheit ? tsd_pkg::SEG_LETTER_F
                                                       : tsd_pkg::SEG_LETTER_C;
            tsd_pkg::FRAME_UNITS:    frame.segments = tsd_pkg::glyph(digits_reg.units);
            tsd_pkg::FRAME_TENS:     frame.segments = tsd_pkg::glyph(digits_reg.tens);
            tsd_pkg::FRAME_HUNDREDS: frame.segments = tsd_pkg::glyph(digits_reg.hundreds);
            default:                 frame.segments = '0;
        endcase
    end

    // The letter sits one place further left in Celsius, which has no hundreds digit.
    assign frame.digit_select = digits_reg.fahrenheit ? (4'b1000 >> index_reg)
                                                      : (4'b0100 >> index_reg);
    assign frame.valid        = valid_reg;
    assign frame.last_frame   = is_last;

endmodule

// ===== hw/rtl/thermometer_seven_segment_display.sv =====
// Top level of the thermometer seven-segment display: conversion pipeline and frame output.
// Depends on tsd_pkg, the tsd_sample_if / tsd_frame_if channels and tsd_framer.
//
//   channel  | direction | word
//   ---------+-----------+--------------------------------------------------
//   sample   | in        | adc_code[7:0], button_level
//   frame    | out       | segments[6:0], digit_select[3:0], last_frame
//
// A sample passes four conversion registers and is then loaded into the frame register.
// It gives three frames (Celsius) or four (Fahrenheit), one per cycle while frames are
// taken; the next sample loads as the last frame goes, so the frame output sets the
// sustained rate. The pipeline stalls stage by stage while frames wait to be taken.
// Reset clears the valid bits, the button history and the mode (Celsius).
module thermometer_seven_segment_display (
    input  logic         clk,
    input  logic         rst_n,
    tsd_sample_if.sink   sample,
    tsd_frame_if.source  frame
);

    logic                              prev_button_reg;
    logic                              mode_reg;
    logic                              mode_next;
    logic                              sample_take;

    logic                              p1_valid_reg;
    logic [tsd_pkg::CODE_W-1:0]        p1_code_reg;
    logic                              p1_mode_reg;
    logic                              p2_valid_reg;
    logic [tsd_pkg::CELSIUS_W-1:0]     p2_celsius_reg;
    logic                              p2_mode_reg;
    logic                              p3_valid_reg;
    logic [tsd_pkg::VALUE_W-1:0]       p3_value_reg;
    logic                              p3_mode_reg;
    logic                              p4_valid_reg;
    logic [tsd_pkg::VALUE_W-1:0]       p4_value_reg;
    logic [6:0]                        p4_q10_reg;
    logic [tsd_pkg::DIGIT_W-1:0]       p4_hundreds_reg;
    logic                              p4_mode_reg;

    logic                              rdy2;
    logic                              rdy3;
    logic                              rdy4;
    logic                              load_ok;
    logic                              load;

    logic [29:0]                       celsius_prod;
    logic [25:0]                       fahr_prod;
    logic [tsd_pkg::VALUE_W-1:0]       value_next;
    logic [17:0]                       q10_prod;
    logic [15:0]                       q100_prod;
    logic [tsd_pkg::VALUE_W-1:0]       units_wide;
    logic [6:0]                        tens_wide;
    tsd_pkg::digits_t                  digits;

    // Each stage takes a word when it is empty or its own word moves on.
    assign load         = p4_valid_reg && load_ok;
    assign rdy4         = !p4_valid_reg || load_ok;
    assign rdy3         = !p3_valid_reg || rdy4;
    assign rdy2         = !p2_valid_reg || rdy3;
    assign sample.ready = !p1_valid_reg || rdy2;
    assign sample_take  = sample.valid && sample.ready;

    // A released-to-pressed edge toggles the mode, effective on this same sample.
    assign mode_next = mode_reg ^ (prev_button_reg && !sample.button_level);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_button_reg <= 1'b0;
            mode_reg        <= 1'b0;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            p3_valid_reg    <= 1'b0;
            p4_valid_reg    <= 1'b0;
        end
        else
        begin
            if (sample_take)
            begin
                prev_button_reg <= sample.button_level;
                mode_reg        <= mode_next;
            end
            if (sample.ready)
            begin
                p1_valid_reg <= sample.valid;
            end
            if (rdy2)
            begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (rdy3)
            begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (rdy4)
            begin
                p4_valid_reg <= p3_valid_reg;
            end
        end
    end

    assign celsius_prod = 30'(p1_code_reg) * 30'(tsd_pkg::CELSIUS_MUL);
    assign fahr_prod    = 26'(p2_celsius_reg) * 26'(tsd_pkg::FAHR_MUL);
    assign value_next   = p2_mode_reg ? (fahr_prod[25:16] + tsd_pkg::FAHR_OFFSET)
                                      : {1'b0, p2_celsius_reg};
    assign q10_prod     = 18'(p3_value_reg) * 18'(tsd_pkg::DIV10_MUL);
    assign q100_prod    = 16'(p3_value_reg) * 16'(tsd_pkg::DIV100_MUL);

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            p1_code_reg <= sample.adc_code;
            p1_mode_reg <= mode_next;
        end
        if (rdy2 && p1_valid_reg)
        begin
            p2_celsius_reg <= celsius_prod[28:20];
            p2_mode_reg    <= p1_mode_reg;
        end
        if (rdy3 && p2_valid_reg)
        begin
            p3_value_reg <= value_next;
            p3_mode_reg  <= p2_mode_reg;
        end
        if (rdy4 && p3_valid_reg)
        begin
            p4_value_reg    <= p3_value_reg;
            p4_q10_reg      <= q10_prod[17:11];
            p4_hundreds_reg <= q100_prod[15:12];
            p4_mode_reg     <= p3_mode_reg;
        end
    end

    // Remainders: units = v - 10 * (v / 10), tens = (v / 10) - 10 * (v / 100).
    assign units_wide = p4_value_reg - ({p4_q10_reg, 3'b000} + {2'b00, p4_q10_reg, 1'b0});
    assign tens_wide  = p4_q10_reg - ({p4_hundreds_reg, 3'b000} + {2'b00, p4_hundreds_reg, 1'b0});

    always_comb
    begin
        digits.fahrenheit = p4_mode_reg;
        digits.hundreds   = p4_hundreds_reg;
        digits.tens       = tens_wide[tsd_pkg::DIGIT_W-1:0];
        digits.units      = units_wide[tsd_pkg::DIGIT_W-1:0];
    end

    tsd_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .digits  (digits),
        .load_ok (load_ok),
        .frame   (frame)
    );

`ifndef SYNTHESIS
    a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid |-> $onehot(frame.digit_select))
        else $error("digit select is not one-hot");

    a_last_is_leftmost: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.last_frame) |-> (frame.digit_select == 4'b0001))
        else $error("last frame does not drive the leftmost digit");

    a_mode_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_take && prev_button_reg && !sample.button_level)
        |=> (mode_reg != $past(mode_reg)))
        else $error("button press did not toggle the mode");

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (digits.units <= 4'd9 && digits.tens <= 4'd9 && digits.hundreds <= 4'd9))
        else $error("decimal split gave a digit above nine");
`endif

endmodule
